// File: sv/line_segment_dash_quad_expander_macros.svh
// Assertion macros for the dashed line quad expander.
// Included by the modules that carry concurrent checks.
`ifndef LINE_SEGMENT_DASH_QUAD_EXPANDER_MACROS_SVH
`define LINE_SEGMENT_DASH_QUAD_EXPANDER_MACROS_SVH

// property that must hold at every edge out of reset
`define LSDQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next
`define LSDQ_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);

`endif

// File: sv/lsdq_pkg.sv
// Shared types, constants and helpers for the dashed line quad expander.
// No dependencies.
package lsdq_pkg;

  localparam int unsigned VERTEX_CAPACITY = 65536;
  localparam int unsigned MAX_DASHES      = 64;
  localparam int unsigned VC_W            = $clog2(VERTEX_CAPACITY + 1);
  localparam int unsigned CNT_W           = $clog2(MAX_DASHES + 1);
  localparam int unsigned QDEPTH          = 2;
  localparam int unsigned QPTR_W          = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W          = $clog2(QDEPTH + 1);

  localparam logic [31:0] MIN_THICK   = 32'd655;
  localparam logic [32:0] MIN_LEN     = 33'd7;
  localparam logic [15:0] ALPHA_ONE   = 16'd16384;
  localparam logic [VC_W:0] QUAD_VERTS = (VC_W + 1)'(6);
  localparam logic [VC_W:0] LINE_VERTS = (VC_W + 1)'(2);
  // floor(x / 100) = (x * RECIP100) >> 38 for any 32-bit x
  localparam logic [31:0] RECIP100    = 32'd2748779070;
  localparam logic [30:0] DIR_ONE     = 31'h4000_0000;

  typedef enum logic [1:0] {
    JOB_CLEAR,
    JOB_WORLD,
    JOB_SOLID,
    JOB_DASH
  } job_kind_e;

  typedef struct packed {
    job_kind_e        kind;
    logic [2:0][31:0] s;
    logic [2:0][31:0] e;
    logic [2:0][30:0] dmag;
    logic [2:0]       dneg;
    logic [32:0]      len;
    logic [30:0]      dash;
    logic [30:0]      gap;
    logic [31:0]      offx;
    logic [31:0]      offy;
    logic [30:0]      width;
    logic [63:0]      color;
  } job_t;

  typedef struct packed {
    logic [2:0][31:0] ps;
    logic [2:0][31:0] pe;
    logic [31:0]      offx;
    logic [31:0]      offy;
    logic [30:0]      width;
    logic [63:0]      color;
    logic             last;
  } piece_t;

  function automatic logic [31:0] sat32(input logic signed [36:0] v);
    logic [31:0] r;
    if (v > 37'sd2147483647) r = 32'h7FFF_FFFF;
    else if (v < -37'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // base +/- round(prod / 2^30), half away from zero
  function automatic logic [31:0] along(input logic [31:0] base, input logic neg,
                                        input logic [63:0] prod);
    logic [64:0] rnd;
    logic signed [36:0] b;
    logic signed [36:0] st;
    rnd = {1'b0, prod} + 65'(64'd1 << 29);
    b   = 37'($signed(base));
    st  = $signed({2'b00, rnd[64:30]});
    return sat32(neg ? (b - st) : (b + st));
  endfunction

endpackage

// File: sv/lsdq_front.sv
// Front end: accepts items, sanitizes style, computes length, direction and offsets.
// Depends on lsdq_pkg.
module lsdq_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 kind_i,
  input  logic signed [31:0]   start_x_i,
  input  logic signed [31:0]   start_y_i,
  input  logic signed [31:0]   start_z_i,
  input  logic signed [31:0]   end_x_i,
  input  logic signed [31:0]   end_y_i,
  input  logic signed [31:0]   end_z_i,
  input  logic [63:0]          color_rgba_i,
  input  logic signed [31:0]   thickness_i,
  input  logic signed [31:0]   dash_length_i,
  input  logic signed [31:0]   gap_length_i,
  input  logic                 hud_mode_i,
  output logic                 job_valid_o,
  input  logic                 job_ready_i,
  output lsdq_pkg::job_t       job_o
);
  import lsdq_pkg::*;

  typedef enum logic [3:0] {
    F_IDLE, F_DEC, F_SQ, F_ROOT, F_LEN, F_WID, F_WSET,
    F_DIV, F_OFFX, F_OFFY, F_OFFE, F_PUSH
  } fstate_e;

  fstate_e st_q;
  logic [4:0] cnt_q;
  job_kind_e jkind_q;

  logic               kind_q, hud_q;
  logic [2:0][31:0]   s_q, e_q;
  logic [63:0]        color_q;
  logic signed [31:0] th_q, dash_q, gap_q;
  logic [63:0]        prod_q, sum_q, x_q, r_q, b_q;
  logic [32:0]        len_q;
  logic [30:0]        width_q;
  logic [31:0]        offx_q, offy_q;
  logic [2:0][32:0]   rem_q;
  logic [2:0][30:0]   quo_q;

  logic [2:0][31:0]   mag;
  logic [2:0][31:0]   mag_sh;
  logic [2:0]         dneg;
  logic               sh;
  logic [15:0]        alpha;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        prod_d, rb;
  logic [32:0]        len_calc;
  logic [2:0][30:0]   dmag;
  logic [63:0]        offr;
  logic [31:0]        offm;
  logic [25:0]        wq;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [32:0] d;
      d = $signed({e_q[i][31], e_q[i]}) - $signed({s_q[i][31], s_q[i]});
      dneg[i] = d[32];
      mag[i]  = d[32] ? 32'(-d) : d[31:0];
      dmag[i] = (quo_q[i] > DIR_ONE) ? DIR_ONE : quo_q[i];
    end
    sh = mag[0][31] | mag[1][31] | mag[2][31];
    for (int i = 0; i < 3; i++) mag_sh[i] = sh ? (mag[i] >> 1) : mag[i];

    if (color_q[63]) alpha = '0;
    else if (color_q[63:48] > ALPHA_ONE) alpha = ALPHA_ONE;
    else alpha = color_q[63:48];

    rb       = r_q + b_q;
    len_calc = sh ? {r_q[31:0], 1'b0} : {1'b0, r_q[31:0]};
    wq       = prod_q[63:38];

    mul_a = '0;
    mul_b = '0;
    case (st_q)
      F_SQ: begin
        mul_a = (cnt_q[1:0] < 2'd3) ? mag_sh[cnt_q[1:0]] : '0;
        mul_b = mul_a;
      end
      F_WID: begin
        mul_a = th_q + 32'd50;
        mul_b = RECIP100;
      end
      F_OFFX: begin
        mul_a = {1'b0, dmag[1]};
        mul_b = {1'b0, width_q};
      end
      F_OFFY: begin
        mul_a = {1'b0, dmag[0]};
        mul_b = {1'b0, width_q};
      end
      default: ;
    endcase
    prod_d = mul_a * mul_b;
    offr   = prod_q + (64'd1 << 30);
    offm   = offr[62:31];
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= F_IDLE;
      cnt_q   <= '0;
      jkind_q <= JOB_CLEAR;
    end else begin
      case (st_q)
        F_IDLE: if (in_valid_i) st_q <= F_DEC;
        F_DEC: begin
          cnt_q <= '0;
          if (kind_q) begin
            jkind_q <= JOB_CLEAR;
            st_q    <= F_PUSH;
          end else if (alpha == '0) begin
            st_q <= F_IDLE;
          end else begin
            st_q <= F_SQ;
          end
        end
        F_SQ: begin
          cnt_q <= (cnt_q == 5'd3) ? '0 : cnt_q + 5'd1;
          if (cnt_q == 5'd3) st_q <= F_ROOT;
        end
        F_ROOT: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) st_q <= F_LEN;
        end
        F_LEN: begin
          if (len_calc <= MIN_LEN) st_q <= F_IDLE;
          else if (!hud_q) begin
            jkind_q <= JOB_WORLD;
            st_q    <= F_PUSH;
          end else st_q <= F_WID;
        end
        F_WID: st_q <= F_WSET;
        F_WSET: begin
          cnt_q <= '0;
          st_q  <= F_DIV;
        end
        F_DIV: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd30) st_q <= F_OFFX;
        end
        F_OFFX: st_q <= F_OFFY;
        F_OFFY: st_q <= F_OFFE;
        F_OFFE: begin
          jkind_q <= (dash_q > 0 && !gap_q[31]) ? JOB_DASH : JOB_SOLID;
          st_q    <= F_PUSH;
        end
        F_PUSH: if (job_ready_i) st_q <= F_IDLE;
        default: st_q <= F_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (st_q)
      F_IDLE: begin
        if (in_valid_i) begin
          kind_q  <= kind_i;
          s_q     <= {start_z_i, start_y_i, start_x_i};
          e_q     <= {end_z_i, end_y_i, end_x_i};
          color_q <= color_rgba_i;
          th_q    <= (thickness_i < $signed(MIN_THICK)) ? $signed(MIN_THICK) : thickness_i;
          dash_q  <= dash_length_i;
          gap_q   <= gap_length_i;
          hud_q   <= hud_mode_i;
        end
      end
      F_SQ: begin
        prod_q <= prod_d;
        sum_q  <= (cnt_q == 5'd0) ? '0 : sum_q + prod_q;
        if (cnt_q == 5'd3) begin
          x_q <= sum_q + prod_q;
          r_q <= '0;
          b_q <= 64'd1 << 62;
        end
      end
      F_ROOT: begin
        if (x_q >= rb) begin
          x_q <= x_q - rb;
          r_q <= (r_q >> 1) + b_q;
        end else begin
          r_q <= r_q >> 1;
        end
        b_q <= b_q >> 2;
      end
      F_LEN: len_q <= len_calc;
      F_WID: prod_q <= prod_d;
      F_WSET: begin
        width_q <= (wq < 26'(MIN_THICK)) ? 31'(MIN_THICK) : 31'(wq);
        for (int i = 0; i < 3; i++) begin
          rem_q[i] <= {2'b00, mag[i][31:1]};
          quo_q[i] <= '0;
        end
      end
      F_DIV: begin
        for (int i = 0; i < 3; i++) begin
          logic [33:0] r2;
          r2 = {rem_q[i], (cnt_q == 5'd0) ? mag[i][0] : 1'b0};
          if (r2 >= {1'b0, len_q}) begin
            rem_q[i] <= 33'(r2 - {1'b0, len_q});
            quo_q[i] <= {quo_q[i][29:0], 1'b1};
          end else begin
            rem_q[i] <= r2[32:0];
            quo_q[i] <= {quo_q[i][29:0], 1'b0};
          end
        end
      end
      F_OFFX: prod_q <= prod_d;
      F_OFFY: begin
        // normal x is -dir_y
        offx_q <= dneg[1] ? offm : -offm;
        prod_q <= prod_d;
      end
      F_OFFE: offy_q <= dneg[0] ? -offm : offm;
      default: ;
    endcase
  end

  assign in_ready_o  = (st_q == F_IDLE);
  assign job_valid_o = (st_q == F_PUSH);

  always_comb begin
    job_o       = '0;
    job_o.kind  = jkind_q;
    job_o.s     = s_q;
    job_o.e     = e_q;
    job_o.dmag  = dmag;
    job_o.dneg  = dneg;
    job_o.len   = len_q;
    job_o.dash  = dash_q[30:0];
    job_o.gap   = gap_q[30:0];
    job_o.offx  = (jkind_q == JOB_WORLD) ? '0 : offx_q;
    job_o.offy  = (jkind_q == JOB_WORLD) ? '0 : offy_q;
    job_o.width = (jkind_q == JOB_WORLD) ? th_q[30:0] : width_q;
    job_o.color = {alpha, color_q[47:0]};
  end

endmodule

// File: sv/lsdq_queue.sv
// Short job queue between front and back end.
// Depends on lsdq_pkg.
module lsdq_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  lsdq_pkg::job_t push_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output lsdq_pkg::job_t pop_o
);
  import lsdq_pkg::*;

  job_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_o        = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
      if (do_pop)  rptr_q <= (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= push_i;
  end

endmodule

// File: sv/lsdq_back.sv
// Back end: dash stepping, capacity accounting and piece output register.
// Depends on lsdq_pkg and the assertion macro header.
module lsdq_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  output logic             job_ready_o,
  input  lsdq_pkg::job_t   job_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output lsdq_pkg::piece_t out_o
);
  import lsdq_pkg::*;
  `include "line_segment_dash_quad_expander_macros.svh"

  typedef enum logic [2:0] {B_IDLE, B_STEP, B_MULS, B_MULE, B_FIN, B_DONE} bstate_e;

  bstate_e          st_q;
  logic [VC_W-1:0]  vc_q;
  logic [CNT_W-1:0] count_q;
  logic [33:0]      cur_q;
  logic [32:0]      de_q;
  logic             pend_vld_q, out_vld_q;
  piece_t           pend_q, out_q;
  job_t             job_q;
  logic [2:0][63:0] prod_q;
  logic [2:0][31:0] ps_q;

  logic             can_push, push_out, clr_take;
  logic [VC_W:0]    vc_line, vc_quad;
  logic [32:0]      rest, de;
  logic [2:0][63:0] prod_d;
  logic [2:0][31:0] pe;
  logic             more, fits;
  piece_t           newp, oneshot, fin_p;

  assign can_push = !out_vld_q || out_ready_i;
  assign push_out = pend_vld_q && can_push && (st_q == B_FIN || st_q == B_DONE);
  assign clr_take = (st_q == B_IDLE) && job_valid_i && (job_i.kind == JOB_CLEAR);
  assign vc_line  = {1'b0, vc_q} + LINE_VERTS;
  assign vc_quad  = {1'b0, vc_q} + QUAD_VERTS;

  always_comb begin
    more = (cur_q < {1'b0, job_q.len}) && (count_q < CNT_W'(MAX_DASHES));
    rest = job_q.len - cur_q[32:0];
    de   = (rest > {2'b00, job_q.dash}) ? (cur_q[32:0] + {2'b00, job_q.dash}) : job_q.len;
    fits = ((de - cur_q[32:0]) > MIN_LEN) && (vc_quad <= (VC_W + 1)'(VERTEX_CAPACITY));
    for (int i = 0; i < 3; i++) begin
      prod_d[i] = 64'(job_q.dmag[i]) * 64'((st_q == B_MULS) ? cur_q[32:0] : de_q);
      pe[i]     = (de_q == job_q.len) ? job_q.e[i] : along(job_q.s[i], job_q.dneg[i], prod_q[i]);
    end
    newp       = '0;
    newp.ps    = ps_q;
    newp.pe    = pe;
    newp.offx  = job_q.offx;
    newp.offy  = job_q.offy;
    newp.width = job_q.width;
    newp.color = job_q.color;
    oneshot       = '0;
    oneshot.ps    = job_i.s;
    oneshot.pe    = job_i.e;
    oneshot.offx  = job_i.offx;
    oneshot.offy  = job_i.offy;
    oneshot.width = job_i.width;
    oneshot.color = job_i.color;
    fin_p      = pend_q;
    fin_p.last = 1'b1;
  end

  assign job_ready_o = (st_q == B_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= B_IDLE;
      vc_q       <= '0;
      count_q    <= '0;
      cur_q      <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      out_vld_q <= push_out || (out_vld_q && !out_ready_i);
      case (st_q)
        B_IDLE: begin
          if (job_valid_i) begin
            job_q <= job_i;
            case (job_i.kind)
              JOB_CLEAR: vc_q <= '0;
              JOB_WORLD: begin
                if (vc_line <= (VC_W + 1)'(VERTEX_CAPACITY)) begin
                  vc_q       <= vc_line[VC_W-1:0];
                  pend_q     <= oneshot;
                  pend_vld_q <= 1'b1;
                  st_q       <= B_DONE;
                end
              end
              JOB_SOLID: begin
                if (vc_quad <= (VC_W + 1)'(VERTEX_CAPACITY)) begin
                  vc_q       <= vc_quad[VC_W-1:0];
                  pend_q     <= oneshot;
                  pend_vld_q <= 1'b1;
                  st_q       <= B_DONE;
                end
              end
              JOB_DASH: begin
                cur_q   <= '0;
                count_q <= '0;
                st_q    <= B_STEP;
              end
              default: ;
            endcase
          end
        end
        B_STEP: begin
          if (!more) st_q <= B_DONE;
          else if (fits) begin
            de_q <= de;
            st_q <= B_MULS;
          end else begin
            cur_q   <= {1'b0, de} + {3'b000, job_q.gap};
            count_q <= count_q + 1'b1;
          end
        end
        B_MULS: begin
          prod_q <= prod_d;
          st_q   <= B_MULE;
        end
        B_MULE: begin
          for (int i = 0; i < 3; i++) ps_q[i] <= along(job_q.s[i], job_q.dneg[i], prod_q[i]);
          prod_q <= prod_d;
          st_q   <= B_FIN;
        end
        B_FIN: begin
          // hold here until the previous piece can move to the output
          if (!pend_vld_q || can_push) begin
            if (pend_vld_q) out_q <= pend_q;
            pend_q     <= newp;
            pend_vld_q <= 1'b1;
            vc_q       <= vc_quad[VC_W-1:0];
            cur_q      <= {1'b0, de_q} + {3'b000, job_q.gap};
            count_q    <= count_q + 1'b1;
            st_q       <= B_STEP;
          end
        end
        B_DONE: begin
          if (!pend_vld_q) st_q <= B_IDLE;
          else if (can_push) begin
            out_q      <= fin_p;
            pend_vld_q <= 1'b0;
            st_q       <= B_IDLE;
          end
        end
        default: st_q <= B_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

  `LSDQ_ASSERT(a_vc_cap, clk_i, rst_ni, {1'b0, vc_q} <= (VC_W + 1)'(VERTEX_CAPACITY), "vertex count over capacity")
  `LSDQ_ASSERT(a_idle_no_pend, clk_i, rst_ni, (st_q != B_IDLE) || !pend_vld_q, "piece left pending between items")
  `LSDQ_ASSERT_NEXT(a_clear, clk_i, rst_ni, clr_take, vc_q == '0, "clear did not reset vertex count")

endmodule

// File: sv/line_segment_dash_quad_expander.sv
// Front steps per drawn segment: squaring, bit-serial root and length check, then for HUD
// items width, bit-serial divide and offsets; each dash piece then passes the back end states
// B_STEP, B_MULS, B_MULE and B_FIN, where it waits until the previous piece can move on. Clears
// and zero-alpha items skip the length math, short segments end after the root. A two-entry job
// queue lets the back emit pieces of one item while the next is prepared.
// Reset (rst_ni low, asynchronous) empties the queue and output and zeroes vertex count.
module line_segment_dash_quad_expander (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 kind_i,
  input  logic signed [31:0]   start_x_i,
  input  logic signed [31:0]   start_y_i,
  input  logic signed [31:0]   start_z_i,
  input  logic signed [31:0]   end_x_i,
  input  logic signed [31:0]   end_y_i,
  input  logic signed [31:0]   end_z_i,
  input  logic [63:0]          color_rgba_i,
  input  logic signed [31:0]   thickness_i,
  input  logic signed [31:0]   dash_length_i,
  input  logic signed [31:0]   gap_length_i,
  input  logic                 hud_mode_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [31:0]   piece_start_x_o,
  output logic signed [31:0]   piece_start_y_o,
  output logic signed [31:0]   piece_start_z_o,
  output logic signed [31:0]   piece_end_x_o,
  output logic signed [31:0]   piece_end_y_o,
  output logic signed [31:0]   piece_end_z_o,
  output logic signed [31:0]   offset_x_o,
  output logic signed [31:0]   offset_y_o,
  output logic [30:0]          width_o,
  output logic [63:0]          out_color_o,
  output logic                 last_o
);
  import lsdq_pkg::*;

  logic   fj_valid, fj_ready, bj_valid, bj_ready;
  job_t   fjob, bjob;
  piece_t piece;

  lsdq_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .kind_i,
    .start_x_i, .start_y_i, .start_z_i, .end_x_i, .end_y_i, .end_z_i,
    .color_rgba_i, .thickness_i, .dash_length_i, .gap_length_i, .hud_mode_i,
    .job_valid_o (fj_valid),
    .job_ready_i (fj_ready),
    .job_o       (fjob)
  );

  lsdq_queue u_queue (
    .clk_i, .rst_ni,
    .push_valid_i (fj_valid),
    .push_ready_o (fj_ready),
    .push_i       (fjob),
    .pop_valid_o  (bj_valid),
    .pop_ready_i  (bj_ready),
    .pop_o        (bjob)
  );

  lsdq_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i (bj_valid),
    .job_ready_o (bj_ready),
    .job_i       (bjob),
    .out_valid_o,
    .out_ready_i,
    .out_o       (piece)
  );

  assign piece_start_x_o = piece.ps[0];
  assign piece_start_y_o = piece.ps[1];
  assign piece_start_z_o = piece.ps[2];
  assign piece_end_x_o   = piece.pe[0];
  assign piece_end_y_o   = piece.pe[1];
  assign piece_end_z_o   = piece.pe[2];
  assign offset_x_o      = piece.offx;
  assign offset_y_o      = piece.offy;
  assign width_o         = piece.width;
  assign out_color_o     = piece.color;
  assign last_o          = piece.last;

endmodule

// File: verif/line_segment_dash_quad_expander_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the dashed line quad expander: watches both channels, predicts
// every emitted piece in fixed point and compares field by field.
// Depends on lsdq_pkg for the capacity and dash cap.
module line_segment_dash_quad_expander_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               kind_i,
  input  logic signed [31:0] start_x_i,
  input  logic signed [31:0] start_y_i,
  input  logic signed [31:0] start_z_i,
  input  logic signed [31:0] end_x_i,
  input  logic signed [31:0] end_y_i,
  input  logic signed [31:0] end_z_i,
  input  logic [63:0]        color_rgba_i,
  input  logic signed [31:0] thickness_i,
  input  logic signed [31:0] dash_length_i,
  input  logic signed [31:0] gap_length_i,
  input  logic               hud_mode_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [31:0]        piece_start_x_i,
  input  logic [31:0]        piece_start_y_i,
  input  logic [31:0]        piece_start_z_i,
  input  logic [31:0]        piece_end_x_i,
  input  logic [31:0]        piece_end_y_i,
  input  logic [31:0]        piece_end_z_i,
  input  logic [31:0]        offset_x_i,
  input  logic [31:0]        offset_y_i,
  input  logic [30:0]        width_i,
  input  logic [63:0]        out_color_i,
  input  logic               last_i,
  output int                 errors_o,
  output int                 pending_o,
  output int                 pieces_o,
  output int                 segments_o
);
  import lsdq_pkg::*;

  typedef struct packed {
    logic [2:0][31:0] ps;
    logic [2:0][31:0] pe;
    logic [31:0]      offx;
    logic [31:0]      offy;
    logic [30:0]      width;
    logic [63:0]      color;
    logic             last;
  } quad_piece_t;

  quad_piece_t pieces_due[$];
  longint unsigned vertex_count;

  initial begin
    errors_o = 0;
    pending_o = 0;
    pieces_o = 0;
    segments_o = 0;
  end

  task automatic mismatch(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    errors_o++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
    if (got !== want) mismatch($sformatf("piece %0d %s got %h want %h", pieces_o, name, got, want));
  endtask

  function automatic longint unsigned root64(input longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic longint step_along(input longint base, input longint unsigned m,
                                        input bit neg, input longint unsigned v);
    longint st;
    st = longint'((m * v + (64'd1 << 29)) >> 30);
    return neg ? base - st : base + st;
  endfunction

  function automatic logic [31:0] half_width(input longint unsigned m, input bit neg,
                                             input longint unsigned w);
    longint h;
    h = longint'((m * w + (64'd1 << 30)) >> 31);
    return neg ? 32'(-h) : 32'(h);
  endfunction

  // expected pieces for the segment on the input ports this cycle
  task automatic expand_segment();
    longint s[3], e[3], d[3];
    longint unsigned mag[3], dmag[3], mx, sum, len, th, w, cur, de, dl, gl;
    bit dneg[3];
    int a, sh, count, n;
    quad_piece_t p;
    if (kind_i) begin
      vertex_count = 0;
      return;
    end
    s[0] = start_x_i; s[1] = start_y_i; s[2] = start_z_i;
    e[0] = end_x_i;   e[1] = end_y_i;   e[2] = end_z_i;
    for (int i = 0; i < 3; i++) begin
      d[i] = e[i] - s[i];
      mag[i] = (d[i] < 0) ? -d[i] : d[i];
      dneg[i] = d[i] < 0;
    end
    th = (thickness_i < 655) ? 655 : thickness_i;
    a = $signed(color_rgba_i[63:48]);
    if (a < 0) a = 0;
    if (a > 16384) a = 16384;
    if (a == 0) return;
    p.color = {16'(a), color_rgba_i[47:0]};
    mx = mag[0];
    if (mag[1] > mx) mx = mag[1];
    if (mag[2] > mx) mx = mag[2];
    sh = (mx >= (64'd1 << 31)) ? 1 : 0;
    sum = 0;
    for (int i = 0; i < 3; i++) sum += (mag[i] >> sh) * (mag[i] >> sh);
    len = root64(sum) << sh;
    if (len <= 7) return;
    for (int i = 0; i < 3; i++) begin
      p.ps[i] = s[i][31:0];
      p.pe[i] = e[i][31:0];
    end
    p.last = 1'b1;
    if (!hud_mode_i) begin
      if (vertex_count + 2 > VERTEX_CAPACITY) return;
      vertex_count += 2;
      p.offx = '0;
      p.offy = '0;
      p.width = th[30:0];
      pieces_due = {pieces_due, p};
      return;
    end
    w = (th + 50) / 100;
    if (w < 655) w = 655;
    p.width = w[30:0];
    for (int i = 0; i < 3; i++) begin
      dmag[i] = (mag[i] << 30) / len;
      if (dmag[i] > (64'd1 << 30)) dmag[i] = 64'd1 << 30;
    end
    p.offx = half_width(dmag[1], !dneg[1], w);
    p.offy = half_width(dmag[0], dneg[0], w);
    if (dash_length_i <= 0 || gap_length_i < 0) begin
      if (vertex_count + 6 > VERTEX_CAPACITY) return;
      vertex_count += 6;
      pieces_due = {pieces_due, p};
      return;
    end
    dl = dash_length_i;
    gl = gap_length_i;
    cur = 0;
    count = 0;
    n = 0;
    while (cur < len && count < MAX_DASHES) begin
      de = (len - cur > dl) ? cur + dl : len;
      if (de - cur > 7 && vertex_count + 6 <= VERTEX_CAPACITY) begin
        for (int i = 0; i < 3; i++) begin
          p.ps[i] = clamp32(step_along(s[i], dmag[i], dneg[i], cur));
          p.pe[i] = (de == len) ? e[i][31:0] : clamp32(step_along(s[i], dmag[i], dneg[i], de));
        end
        p.last = 1'b0;
        vertex_count += 6;
        pieces_due = {pieces_due, p};
        n++;
      end
      cur = de + gl;
      count++;
    end
    if (n > 0) pieces_due[pieces_due.size() - 1].last = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    quad_piece_t want;
    if (!rst_ni) begin
      vertex_count = 0;
      pieces_due.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        expand_segment();
        segments_o++;
      end
      if (out_valid_i && out_ready_i) begin
        if (pieces_due.size() == 0) begin
          mismatch("piece transfer with nothing expected");
        end else begin
          want = pieces_due.pop_front();
          check_field("start_x", piece_start_x_i, want.ps[0]);
          check_field("start_y", piece_start_y_i, want.ps[1]);
          check_field("start_z", piece_start_z_i, want.ps[2]);
          check_field("end_x", piece_end_x_i, want.pe[0]);
          check_field("end_y", piece_end_y_i, want.pe[1]);
          check_field("end_z", piece_end_z_i, want.pe[2]);
          check_field("offset_x", offset_x_i, want.offx);
          check_field("offset_y", offset_y_i, want.offy);
          check_field("width", width_i, want.width);
          check_field("color", out_color_i, want.color);
          check_field("last", last_i, want.last);
        end
        pieces_o++;
      end
      pending_o <= pieces_due.size();
    end
  end

endmodule

// File: verif/line_segment_dash_quad_expander_test.sv
`timescale 1ns / 1ps
// Top of the dashed line quad expander testbench: clock, reset, segment stimulus
// and output back-pressure. Depends on the block and line_segment_dash_quad_expander_checker.
module line_segment_dash_quad_expander_test;

  typedef struct {
    logic        kind;
    logic [31:0] sx, sy, sz, ex, ey, ez;
    logic [63:0] color;
    logic [31:0] thick, dash, gap;
    logic        hud;
  } segment_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic kind = 1'b0;
  logic signed [31:0] sx = '0, sy = '0, sz = '0, ex = '0, ey = '0, ez = '0;
  logic [63:0] color = '0;
  logic signed [31:0] thick = '0, dash = '0, gap = '0;
  logic hud = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] psx, psy, psz, pex, pey, pez, offx, offy;
  logic [30:0] width;
  logic [63:0] out_color;
  logic last;

  int errors, pending, pieces, segments;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  bit hold_request = 0;

  line_segment_dash_quad_expander dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .kind_i(kind),
    .start_x_i(sx), .start_y_i(sy), .start_z_i(sz),
    .end_x_i(ex), .end_y_i(ey), .end_z_i(ez),
    .color_rgba_i(color), .thickness_i(thick), .dash_length_i(dash),
    .gap_length_i(gap), .hud_mode_i(hud),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .piece_start_x_o(psx), .piece_start_y_o(psy), .piece_start_z_o(psz),
    .piece_end_x_o(pex), .piece_end_y_o(pey), .piece_end_z_o(pez),
    .offset_x_o(offx), .offset_y_o(offy), .width_o(width),
    .out_color_o(out_color), .last_o(last)
  );

  line_segment_dash_quad_expander_checker scoreboard (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .kind_i(kind),
    .start_x_i(sx), .start_y_i(sy), .start_z_i(sz),
    .end_x_i(ex), .end_y_i(ey), .end_z_i(ez),
    .color_rgba_i(color), .thickness_i(thick), .dash_length_i(dash),
    .gap_length_i(gap), .hud_mode_i(hud),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .piece_start_x_i(psx), .piece_start_y_i(psy), .piece_start_z_i(psz),
    .piece_end_x_i(pex), .piece_end_y_i(pey), .piece_end_z_i(pez),
    .offset_x_i(offx), .offset_y_i(offy), .width_i(width),
    .out_color_i(out_color), .last_i(last),
    .errors_o(errors), .pending_o(pending), .pieces_o(pieces), .segments_o(segments)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #30ms;
    $display("Timeout with %0d pieces outstanding", pending);
    $display("Simulation FAILED");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off when requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_request = 0;
      end
      out_ready <= (rx_stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic send_segment(input segment_t t);
    bit took;
    kind <= t.kind;
    sx <= t.sx; sy <= t.sy; sz <= t.sz;
    ex <= t.ex; ey <= t.ey; ez <= t.ez;
    color <= t.color;
    thick <= t.thick; dash <= t.dash; gap <= t.gap;
    hud <= t.hud;
    in_valid <= 1'b1;
    took = 0;
    while (!took) begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  function automatic segment_t make_seg(input logic k, input int x0, input int y0,
      input int z0, input int x1, input int y1, input int z1, input logic [15:0] alpha,
      input int th, input int dl, input int gl, input logic h);
    segment_t t;
    t.kind = k;
    t.sx = x0; t.sy = y0; t.sz = z0;
    t.ex = x1; t.ey = y1; t.ez = z1;
    t.color = {alpha, 48'h1234_5678_9ABC};
    t.thick = th; t.dash = dl; t.gap = gl;
    t.hud = h;
    return t;
  endfunction

  // plausible segment; dense ones hit the dash cap
  function automatic segment_t plausible_seg(input bit dense);
    segment_t t;
    t.kind = 0;
    t.sx = $urandom_range(0, 2**27) - 2**26;
    t.sy = $urandom_range(0, 2**27) - 2**26;
    t.sz = $urandom_range(0, 2**27) - 2**26;
    t.ex = t.sx + $urandom_range(0, 2**23) - 2**22;
    t.ey = t.sy + $urandom_range(0, 2**23) - 2**22;
    t.ez = t.sz + $urandom_range(0, 2**23) - 2**22;
    t.color[47:0] = {$urandom, $urandom};
    t.color[63:48] = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 16384));
    t.thick = ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 2**22);
    if (dense) begin
      t.dash = $urandom_range(16, 2**14);
      t.gap = $urandom_range(0, 2**13);
      t.hud = 1;
    end else begin
      t.dash = $urandom_range(2**15, 2**22);
      t.gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(0, 2**21);
      t.hud = $urandom_range(3) != 0;
    end
    return t;
  endfunction

  function automatic segment_t random_seg();
    segment_t t;
    int pick;
    pick = $urandom_range(99);
    if (pick < 3) begin
      t = plausible_seg(0);
      t.kind = 1;
    end else if (pick < 73) begin
      t = plausible_seg($urandom_range(9) < 3);
    end else begin
      t.kind = 0;
      t.sx = $urandom; t.sy = $urandom; t.sz = $urandom;
      t.ex = $urandom; t.ey = $urandom; t.ez = $urandom;
      t.color = {$urandom, $urandom};
      t.thick = $urandom; t.dash = $urandom; t.gap = $urandom;
      t.hud = $urandom_range(1);
    end
    return t;
  endfunction

  task automatic random_phase(input int n, input int tx, input int rx);
    tx_idle_pct = tx;
    rx_stall_pct = rx;
    repeat (n) send_segment(random_seg());
    drain();
  endtask

  localparam int ONE = 65536;
  localparam int IMIN = 32'h8000_0000;
  localparam int IMAX = 32'h7FFF_FFFF;

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: modes, style sanitizing, drop rules, extremes
    send_segment(make_seg(0, 0, 0, 0, 10*ONE, 0, 0, 16384, ONE, 0, 0, 0));
    send_segment(make_seg(0, 0, 0, 0, 10*ONE, 2*ONE, 0, 16384, 3*ONE, 0, 0, 1));
    send_segment(make_seg(0, 3*ONE, 4*ONE, 0, 0, 0, 0, 8000, 3*ONE, ONE, ONE, 1));
    send_segment(make_seg(0, 0, 0, 0, 0, 5*ONE, 0, 8000, 3*ONE, ONE, 0, 1));
    send_segment(make_seg(0, 0, 0, 0, 5*ONE, 5*ONE, 0, 8000, 3*ONE, ONE, -1, 1));
    send_segment(make_seg(0, 0, 0, 0, 5*ONE, 5*ONE, 0, 8000, 3*ONE, -ONE, ONE, 1));
    send_segment(make_seg(0, 0, 0, 0, 5*ONE, 0, 0, 16'h0000, ONE, 0, 0, 1));
    send_segment(make_seg(0, 0, 0, 0, 5*ONE, 0, 0, 16'h8000, ONE, 0, 0, 1));
    send_segment(make_seg(0, 0, 0, 0, 5*ONE, 0, 0, 16'h7FFF, ONE, 0, 0, 0));
    send_segment(make_seg(0, 0, 0, 0, 5*ONE, ONE, 0, 16384, -5, 0, 0, 1));
    send_segment(make_seg(0, 0, 0, 0, 5*ONE, ONE, ONE, 16384, IMAX, 0, 0, 1));
    send_segment(make_seg(0, ONE, ONE, ONE, ONE, ONE, ONE, 16384, ONE, 0, 0, 0));
    send_segment(make_seg(0, 0, 0, 0, 7, 0, 0, 16384, ONE, 0, 0, 0));
    send_segment(make_seg(0, 0, 0, 0, 8, 0, 0, 16384, ONE, 0, 0, 1));
    send_segment(make_seg(0, 0, 0, 0, 40, 0, 0, 16384, ONE, 9, 0, 1));
    send_segment(make_seg(0, IMIN, IMIN, IMIN, IMAX, IMAX, IMAX, 16'hFFFF, IMAX, 0, 0, 0));
    send_segment(make_seg(0, IMIN, IMIN, IMIN, IMAX, IMAX, IMAX, 100, ONE, IMAX, IMAX, 1));
    send_segment(make_seg(0, IMIN, IMAX, IMIN, IMAX, IMIN, IMAX, 16384, ONE, 2**26, 0, 1));
    send_segment(make_seg(0, 5*ONE, 5*ONE, 5*ONE, -5*ONE, -5*ONE, -5*ONE, 1, ONE, ONE, 7, 1));
    send_segment(make_seg(0, 0, 0, 0, 0, 0, 9*ONE, 16384, ONE, ONE/2, ONE/4, 1));
    send_segment(make_seg(1, 0, 0, 0, 0, 0, 0, 16384, 0, 0, 0, 0));
    drain();

    // fill the vertex store with dense dashed segments until it overflows
    repeat (200) send_segment(plausible_seg(1));
    drain();
    send_segment(make_seg(1, 0, 0, 0, 0, 0, 0, 16384, 0, 0, 0, 0));

    random_phase(35, 83, 0);
    random_phase(35, 0, 83);
    random_phase(35, 16, 16);

    // long receiver hold-off while the sender keeps offering
    hold_request = 1;
    random_phase(20, 0, 0);

    $display("Sent %0d segments incl. clears, capacity overflow and dash cap; %0d pieces checked",
             segments, pieces);
    $display("Idling phases: none, sender 83%%, receiver 83%%, both 16%%, one long hold-off");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
